// ----- sv/ncr_pkg.sv -----
// Shared types, character codes and escape helpers for the character reference decoder.
package ncr_pkg;

   // One input item: a raw byte of the reference and its end flag
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // One result item: a byte of escaped UTF-8 text
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // Up to four unescaped bytes that one input item produces
   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
   } sym_list_type;

   // Byte position within the reference
   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_SECOND = 2'd1,
      POS_THIRD  = 2'd2,
      POS_DIGITS = 2'd3
   } pos_type;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_QUOT = 8'h22;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_LT   = 8'h3c;
   localparam logic [7:0] CH_GT   = 8'h3e;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_LA   = 8'h61;
   localparam logic [7:0] CH_LZ   = 8'h7a;
   localparam logic [7:0] CH_LX   = 8'h78;
   localparam logic [7:0] CH_UX   = 8'h58;

   localparam logic [20:0] MAX_POINT   = 21'h10ffff;
   localparam logic [20:0] REPLACEMENT = 21'h00fffd;
   localparam logic [20:0] SURR_LO     = 21'h00d800;
   localparam logic [20:0] SURR_HI     = 21'h00dfff;
   localparam logic [20:0] LIM_DEC     = 21'(21'h10ffff / 10);
   localparam logic [20:0] LIM_HEX     = 21'(21'h10ffff / 16);

   // Most bytes one item may produce
   localparam logic [3:0] MAX_OUT = 4'd12;

   // Number of output bytes an escaped byte expands to
   function automatic logic [2:0] esc_len(input logic [7:0] b);
      logic [2:0] n;
      case (b)
         CH_AMP:  n = 3'd5;
         CH_LT:   n = 3'd4;
         CH_GT:   n = 3'd4;
         CH_QUOT: n = 3'd6;
         CH_NUL:  n = 3'd3;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   // Byte k of the escaped form of b
   function automatic logic [7:0] esc_byte(input logic [7:0] b, input logic [2:0] k);
      logic [7:0] r;
      r = b;
      case (b)
         CH_AMP: begin
            case (k)
               3'd0:    r = "&";
               3'd1:    r = "a";
               3'd2:    r = "m";
               3'd3:    r = "p";
               default: r = ";";
            endcase
         end
         CH_LT: begin
            case (k)
               3'd0:    r = "&";
               3'd1:    r = "l";
               3'd2:    r = "t";
               default: r = ";";
            endcase
         end
         CH_GT: begin
            case (k)
               3'd0:    r = "&";
               3'd1:    r = "g";
               3'd2:    r = "t";
               default: r = ";";
            endcase
         end
         CH_QUOT: begin
            case (k)
               3'd0:    r = "&";
               3'd1:    r = "q";
               3'd2:    r = "u";
               3'd3:    r = "o";
               3'd4:    r = "t";
               default: r = ";";
            endcase
         end
         CH_NUL: begin
            case (k)
               3'd0:    r = 8'hef;
               3'd1:    r = 8'hbf;
               default: r = 8'hbd;
            endcase
         end
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/ncr_decode.sv -----
// Reference parser: position tracking, digit accumulation and UTF-8 encoding.
module ncr_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ncr_pkg::req_type      req_data,
   output ncr_pkg::sym_list_type sym_list
);

   ncr_pkg::pos_type pos_ff, pos_in;
   logic             hex_ff, hex_in;
   logic [20:0]      point_ff, point_in;
   logic             bad_ff, bad_in;
   logic             pass_ff, pass_in;
   logic [7:0]       held_ff, held_in;

   logic [7:0]  c;
   logic        last;
   logic [7:0]  lc;
   logic [5:0]  dig_val;
   logic        dig_ok;
   logic [20:0] lim;
   logic [20:0] scaled;
   logic [20:0] acc_point;
   logic        acc_bad;
   logic [20:0] cp;

   assign c    = req_data.in_byte;
   assign last = req_data.in_last;
   assign lc   = c | 8'h20;

   // Digit value in the current base, and the accumulate step
   always_comb begin
      dig_val = 6'd63;
      if (c >= ncr_pkg::CH_0 && c <= ncr_pkg::CH_9) begin
         dig_val = 6'(c - ncr_pkg::CH_0);
      end else if (lc >= ncr_pkg::CH_LA && lc <= ncr_pkg::CH_LZ) begin
         dig_val = 6'(lc - ncr_pkg::CH_LA) + 6'd10;
      end
      dig_ok = hex_ff ? (dig_val < 6'd16) : (dig_val < 6'd10);
      lim    = hex_ff ? ncr_pkg::LIM_HEX : ncr_pkg::LIM_DEC;
      scaled = hex_ff ? {point_ff[16:0], 4'b0000}
                      : ({point_ff[17:0], 3'b000} + {point_ff[19:0], 1'b0});
      acc_point = point_ff;
      acc_bad   = bad_ff;
      if (!bad_ff) begin
         if (!dig_ok || point_ff > lim) begin
            acc_point = ncr_pkg::REPLACEMENT;
            acc_bad   = 1'b1;
         end else begin
            acc_point = scaled + {15'd0, dig_val};
         end
      end
   end

   // Code point check before encoding
   always_comb begin
      cp = point_ff;
      if (point_ff == 21'd0 || point_ff > ncr_pkg::MAX_POINT ||
          (point_ff >= ncr_pkg::SURR_LO && point_ff <= ncr_pkg::SURR_HI)) begin
         cp = ncr_pkg::REPLACEMENT;
      end
   end

   // Next state and the bytes this item produces
   always_comb begin
      pos_in   = pos_ff;
      hex_in   = hex_ff;
      point_in = point_ff;
      bad_in   = bad_ff;
      pass_in  = pass_ff;
      held_in  = held_ff;
      sym_list = '0;
      if (pass_ff) begin
         sym_list.count    = 3'd1;
         sym_list.bytes[0] = c;
      end else begin
         case (pos_ff)
            ncr_pkg::POS_FIRST: begin
               if (last) begin
                  sym_list.count    = 3'd1;
                  sym_list.bytes[0] = c;
               end else begin
                  held_in = c;
               end
               pos_in = ncr_pkg::POS_SECOND;
            end
            ncr_pkg::POS_SECOND: begin
               if (c != ncr_pkg::CH_HASH) begin
                  sym_list.count    = 3'd2;
                  sym_list.bytes[0] = held_ff;
                  sym_list.bytes[1] = c;
                  pass_in           = 1'b1;
               end else if (last) begin
                  sym_list.count    = 3'd2;
                  sym_list.bytes[0] = held_ff;
                  sym_list.bytes[1] = ncr_pkg::CH_HASH;
               end
               pos_in = ncr_pkg::POS_THIRD;
            end
            ncr_pkg::POS_THIRD: begin
               if (last) begin
                  sym_list.count    = 3'd3;
                  sym_list.bytes[0] = held_ff;
                  sym_list.bytes[1] = ncr_pkg::CH_HASH;
                  sym_list.bytes[2] = c;
               end else if (c == ncr_pkg::CH_LX || c == ncr_pkg::CH_UX) begin
                  hex_in = 1'b1;
               end else begin
                  point_in = acc_point;
                  bad_in   = acc_bad;
               end
               pos_in = ncr_pkg::POS_DIGITS;
            end
            ncr_pkg::POS_DIGITS: begin
               if (last) begin
                  // UTF-8 encode the checked code point
                  if (cp < 21'h80) begin
                     sym_list.count    = 3'd1;
                     sym_list.bytes[0] = cp[7:0];
                  end else if (cp < 21'h800) begin
                     sym_list.count    = 3'd2;
                     sym_list.bytes[0] = {3'b110, cp[10:6]};
                     sym_list.bytes[1] = {2'b10, cp[5:0]};
                  end else if (cp < 21'h10000) begin
                     sym_list.count    = 3'd3;
                     sym_list.bytes[0] = {4'b1110, cp[15:12]};
                     sym_list.bytes[1] = {2'b10, cp[11:6]};
                     sym_list.bytes[2] = {2'b10, cp[5:0]};
                  end else begin
                     sym_list.count    = 3'd4;
                     sym_list.bytes[0] = {5'b11110, cp[20:18]};
                     sym_list.bytes[1] = {2'b10, cp[17:12]};
                     sym_list.bytes[2] = {2'b10, cp[11:6]};
                     sym_list.bytes[3] = {2'b10, cp[5:0]};
                  end
               end else begin
                  point_in = acc_point;
                  bad_in   = acc_bad;
               end
            end
            default: pos_in = ncr_pkg::POS_FIRST;
         endcase
      end
      // End of reference clears everything
      if (last) begin
         pos_in   = ncr_pkg::POS_FIRST;
         hex_in   = 1'b0;
         point_in = '0;
         bad_in   = 1'b0;
         pass_in  = 1'b0;
         held_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= ncr_pkg::POS_FIRST;
         hex_ff   <= 1'b0;
         point_ff <= '0;
         bad_ff   <= 1'b0;
         pass_ff  <= 1'b0;
         held_ff  <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         hex_ff   <= hex_in;
         point_ff <= point_in;
         bad_ff   <= bad_in;
         pass_ff  <= pass_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ----- sv/ncr_serial.sv -----
// Result register and escaping serializer: one output byte per cycle while the output is not stalled.
module ncr_serial (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ncr_pkg::sym_list_type sym_list,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ncr_pkg::rsp_type      rsp_data
);

   logic [3:0][7:0] sym_ff, sym_in;
   logic [2:0]      nsym_ff, nsym_in;
   logic [1:0]      idx_ff, idx_in;
   logic [2:0]      sub_ff, sub_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;

   logic [7:0] cur;
   logic [2:0] len;
   logic       last_sub;
   logic       final_byte;
   logic       emit;

   // Current escaped byte and whether it closes the item
   always_comb begin
      cur        = sym_ff[idx_ff];
      len        = ncr_pkg::esc_len(cur);
      last_sub   = (sub_ff == len - 3'd1);
      final_byte = (last_sub && ({1'b0, idx_ff} == nsym_ff - 3'd1)) ||
                   (cnt_ff == ncr_pkg::MAX_OUT - 4'd1);
      emit       = busy_ff && !rsp_stall;
      free       = !busy_ff || (emit && final_byte);
   end

   assign rsp_valid         = busy_ff;
   assign rsp_data.out_byte = ncr_pkg::esc_byte(cur, sub_ff);
   assign rsp_data.out_last = final_byte;

   // Advance through symbols and their escape sequences
   always_comb begin
      sym_in  = sym_ff;
      nsym_in = nsym_ff;
      idx_in  = idx_ff;
      sub_in  = sub_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (load) begin
         sym_in  = sym_list.bytes;
         nsym_in = sym_list.count;
         idx_in  = '0;
         sub_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (emit) begin
         cnt_in = cnt_ff + 4'd1;
         if (final_byte) begin
            busy_in = 1'b0;
         end else if (last_sub) begin
            idx_in = idx_ff + 2'd1;
            sub_in = '0;
         end else begin
            sub_in = sub_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         nsym_ff <= '0;
         idx_ff  <= '0;
         sub_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         nsym_ff <= nsym_in;
         idx_ff  <= idx_in;
         sub_ff  <= sub_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
   end

endmodule

// ----- sv/numeric_char_ref_to_utf8.sv -----
// Numeric character reference decoder with escaped UTF-8 output: top level.
// The first output byte of an item appears in the cycle after it is accepted.
// Throughput: one item per cycle with no output stall while each item yields at most one
//   byte; a longer item (up to 12 bytes) holds the serializer and the input until its
//   last byte leaves. Items that yield no bytes are absorbed without using the serializer.
// Reset (synchronous, active high) clears the parser state and empties the serializer.
module numeric_char_ref_to_utf8 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ncr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ncr_pkg::rsp_type rsp_data
);

   ncr_pkg::sym_list_type sym_list;
   logic                  free;
   logic                  accept;

   assign req_stall = !free;
   assign accept    = req_valid && free;

   ncr_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .sym_list (sym_list)
   );

   ncr_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && (sym_list.count != 3'd0)),
      .sym_list  (sym_list),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/ncr_checker.sv -----
// Port-level checks for the character reference decoder, bound to the top level.
module ncr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ncr_pkg::rsp_type rsp_data
);

   // A stalled output item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled output item changed");

   // Output is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   // Input is held back only while output bytes are pending
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

   // No new item while the current one still has bytes to send
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_last |-> req_stall)
      else $error("input taken mid-sequence");

   // Draining the final byte frees the input in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_last && !rsp_stall |-> !req_stall)
      else $error("input stalled after final byte left");

endmodule

bind numeric_char_ref_to_utf8 ncr_checker u_ncr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
